// ===== sv/asbs_pkg.sv =====
// Shared types and constants for the Annex B start code splitter.
package asbs_pkg;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic [7:0] BYTE_ZERO = 8'h00;
    localparam logic [7:0] BYTE_ONE  = 8'h01;

    localparam logic [1:0] ZRUN_MAX = 2'd3;
    localparam logic [1:0] ZRUN_SC  = 2'd2;

    localparam logic [2:0] PREFIX_NONE  = 3'd0;
    localparam logic [2:0] PREFIX_SHORT = 3'd3;
    localparam logic [2:0] PREFIX_LONG  = 3'd4;

    localparam logic ACTION_DATA  = 1'b0;
    localparam logic ACTION_FLUSH = 1'b1;

    // One back-end command: push nzeros zero bytes, then push data or close the unit.
    typedef struct packed {
        logic [1:0] nzeros;
        logic       push_b;
        logic [7:0] data;
        logic [2:0] prefix;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic valid;
    } fifo_status_t;

endpackage

// ===== sv/asbs_fifo.sv =====
// Command queue between the front classifier and the back unit builder.
module asbs_fifo
    import asbs_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  cmd_t         push_cmd,
    input  logic         pop,
    output cmd_t         head_cmd,
    output fifo_status_t status
);

    cmd_t                  mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0] count_reg, count_next;
    logic                  do_push, do_pop;

    assign status.full  = (count_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign status.valid = (count_reg != '0);
    assign head_cmd     = mem_reg[rd_ptr_reg];

    assign do_push = push && !status.full;
    assign do_pop  = pop && status.valid;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!do_push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== sv/asbs_front.sv =====
// Front end: accepts stream bytes, tracks the zero run and classifies each transaction.
module asbs_front
    import asbs_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       s_tuser,
    input  logic       fifo_full,
    output logic       cmd_push,
    output cmd_t       cmd
);

    logic [1:0] zero_run_reg, zero_run_next;
    logic       accept;
    logic       need_cmd;

    assign s_tready = !fifo_full;
    assign accept   = s_tvalid && s_tready;
    assign cmd_push = accept && need_cmd;

    always_comb begin
        zero_run_next = zero_run_reg;
        need_cmd      = 1'b1;
        cmd.nzeros    = zero_run_reg;
        cmd.push_b    = 1'b1;
        cmd.data      = s_tdata;
        cmd.prefix    = PREFIX_NONE;
        if (s_tuser == ACTION_FLUSH) begin
            cmd.push_b    = 1'b0;
            zero_run_next = '0;
        end else if (s_tdata == BYTE_ZERO) begin
            cmd.nzeros = '0;
            if (zero_run_reg != ZRUN_MAX) begin
                need_cmd      = 1'b0;
                zero_run_next = zero_run_reg + 1'b1;
            end
        end else if (s_tdata == BYTE_ONE && zero_run_reg >= ZRUN_SC) begin
            cmd.nzeros    = '0;
            cmd.push_b    = 1'b0;
            cmd.prefix    = (zero_run_reg == ZRUN_MAX) ? PREFIX_LONG : PREFIX_SHORT;
            zero_run_next = '0;
        end else begin
            zero_run_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zero_run_reg <= '0;
        end else if (accept) begin
            zero_run_reg <= zero_run_next;
        end
    end

endmodule

// ===== sv/asbs_back.sv =====
// Back end: runs queued commands one step a cycle while the output register is free, and drives the output register.
module asbs_back
    import asbs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cmd_valid,
    input  cmd_t        cmd,
    output logic        cmd_pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,
    output logic        m_tuser,
    output logic        m_tlast
);

    logic [7:0] held_byte_reg, held_byte_next;
    logic       held_valid_reg, held_valid_next;
    logic       held_first_reg, held_first_next;
    logic [2:0] prefix_reg, prefix_next;
    logic [1:0] zcnt_reg, zcnt_next;

    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic [2:0] out_prefix_reg;
    logic       out_first_reg, out_last_reg;

    logic       out_free, op_go, op_zero, op_push, emit;
    logic [7:0] op_byte;

    assign out_free = !out_valid_reg || m_tready;
    assign op_go    = cmd_valid && out_free;
    assign op_zero  = (zcnt_reg != cmd.nzeros);
    assign op_push  = op_zero || cmd.push_b;
    assign op_byte  = op_zero ? BYTE_ZERO : cmd.data;
    assign emit     = op_go && held_valid_reg;
    assign cmd_pop  = op_go && !op_zero;

    always_comb begin
        held_byte_next  = held_byte_reg;
        held_valid_next = held_valid_reg;
        held_first_next = held_first_reg;
        prefix_next     = prefix_reg;
        zcnt_next       = zcnt_reg;
        if (op_go) begin
            zcnt_next = op_zero ? zcnt_reg + 1'b1 : '0;
            if (op_push) begin
                held_byte_next  = op_byte;
                held_valid_next = 1'b1;
                if (held_valid_reg) begin
                    held_first_next = 1'b0;
                end
            end else begin
                held_byte_next  = BYTE_ZERO;
                held_valid_next = 1'b0;
                held_first_next = 1'b1;
                prefix_next     = cmd.prefix;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_valid_reg <= 1'b0;
            held_first_reg <= 1'b1;
            prefix_reg     <= PREFIX_NONE;
            zcnt_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            held_valid_reg <= held_valid_next;
            held_first_reg <= held_first_next;
            prefix_reg     <= prefix_next;
            zcnt_reg       <= zcnt_next;
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        held_byte_reg <= held_byte_next;
        if (emit) begin
            out_byte_reg   <= held_byte_reg;
            out_first_reg  <= held_first_reg;
            out_last_reg   <= !op_push;
            out_prefix_reg <= prefix_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_prefix_reg, out_byte_reg};
    assign m_tuser  = out_first_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ===== sv/annexb_start_code_splitter_top.sv =====
// Top level of the Annex B start code splitter: front classifier, command queue, back unit.
// Throughput: one input transaction per cycle while the queue has room; the back unit runs
// one step per cycle while its output register is free and replays held zeros first.
// A byte passes through the command queue, the held byte register and the output register.
// Reset: aresetn is synchronous, active low; clears the zero run, queue and output valid,
// and opens a unit with prefix 0.
module annexb_start_code_splitter_top
    import asbs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] stream_byte
    input  logic        s_tuser,   // [0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] unit_byte, [10:8] prefix_length, [15:11] zero
    output logic        m_tuser,   // [0] first_of_unit
    output logic        m_tlast    // last_of_unit
);

    cmd_t         push_cmd, head_cmd;
    logic         cmd_push, cmd_pop;
    fifo_status_t fifo_st;

    asbs_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .fifo_full (fifo_st.full),
        .cmd_push  (cmd_push),
        .cmd       (push_cmd)
    );

    asbs_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (cmd_push),
        .push_cmd (push_cmd),
        .pop      (cmd_pop),
        .head_cmd (head_cmd),
        .status   (fifo_st)
    );

    asbs_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (fifo_st.valid),
        .cmd       (head_cmd),
        .cmd_pop   (cmd_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    a_pop_needs_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_pop |-> fifo_st.valid)
        else $error("command popped from empty queue");

    a_push_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_push |-> !fifo_st.full)
        else $error("command pushed into full queue");

    a_prefix_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[10:8] == PREFIX_NONE || m_tdata[10:8] == PREFIX_SHORT
                      || m_tdata[10:8] == PREFIX_LONG))
        else $error("illegal prefix length on output");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule
